// ===== hdl/max_height_grid_binning_macros.svh =====
`ifndef MAX_HEIGHT_GRID_BINNING_MACROS_SVH
`define MAX_HEIGHT_GRID_BINNING_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MHGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds starting in the cycle after the antecedent.
`define MHGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mhgb_pkg.sv =====
package mhgb_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;

  // Filled flags are kept 64 to a memory row so that a clear sweeps few rows.
  localparam int FILL_WIDTH     = 64;
  localparam int FILL_SEL_BITS  = $clog2(FILL_WIDTH);
  localparam int FILL_DEPTH     = CELL_COUNT / FILL_WIDTH;
  localparam int FILL_ADDR_BITS = ADDR_BITS - FILL_SEL_BITS;

  localparam int COORD_BITS   = 32;
  localparam int SPACING_BITS = 20;
  localparam int SIZE_BITS    = 9;
  localparam int DIV_BITS     = 32;
  localparam int DIV_ITERS    = DIV_BITS / 2;
  localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_CELL_SPACING = 3'd2;
  localparam logic [2:0] REG_GRID_COLUMNS = 3'd3;
  localparam logic [2:0] REG_GRID_ROWS    = 3'd4;
  localparam logic [2:0] REG_EMPTY_HEIGHT = 3'd5;

  typedef struct packed {
    logic                    start;
    logic [DIV_BITS-1:0]     dividend;
    logic [SPACING_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/mhgb_ram.sv =====
module mhgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mhgb_divider.sv =====
module mhgb_divider
  import mhgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0]     dvd;
  logic [SPACING_BITS-1:0] dsr;
  logic [SPACING_BITS-1:0] rem;

  logic [SPACING_BITS:0]   t1, t2;
  logic                    ge1, ge2;
  logic [SPACING_BITS-1:0] r1, r2;

  // Two restoring steps per cycle; the dividend shifts out at the top while
  // quotient bits shift in at the bottom.
  always_comb begin
    t1  = {rem, dvd[DIV_BITS-1]};
    ge1 = t1 >= {1'b0, dsr};
    r1  = ge1 ? SPACING_BITS'(t1 - {1'b0, dsr}) : t1[SPACING_BITS-1:0];
    t2  = {r1, dvd[DIV_BITS-2]};
    ge2 = t2 >= {1'b0, dsr};
    r2  = ge2 ? SPACING_BITS'(t2 - {1'b0, dsr}) : t2[SPACING_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        // A zero spacing divides as one.
        dsr  <= (req.divisor == '0) ? SPACING_BITS'(1) : req.divisor;
      end else if (busy) begin
        rem <= r2;
        dvd <= {dvd[DIV_BITS-3:0], ge1, ge2};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: dvd};

endmodule

// ===== hdl/max_height_grid_binning.sv =====
// Channel  Dir  Handshake                 Payload
// s        in   s_tvalid / s_tready       s_tdata: point_x, point_y, point_z, read_row,
//                                         read_column; s_tuser: operation
// m        out  m_tvalid / m_tready       m_tdata: cell_height; m_tuser: cell_empty
// cfg      in   psel / penable / pready   paddr, pwdata, pwrite, prdata
//
// An add word keeps the input busy through two divisions by the cell spacing in one
// shared radix-4 divider (start, 16 steps, done each), then a read-modify-write of one
// cell in the height memory. A read word goes through a fetch and a use step to the
// output register and waits in the use step while that register is full.
// A clear word, and reset, sweep the filled-flag memory one 64-cell row per cycle over
// all 1024 rows, during which no word is accepted. Reset is synchronous, active high.
// The output register holds a result until it is taken; a stalled output holds a
// read in its last step.
module max_height_grid_binning
  import mhgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // point_x, point_y, point_z, read_row, read_column
  input  logic [1:0]   s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // cell_height
  output logic [0:0]   m_tuser,  // cell_empty
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_XSTART = 3'd2;
  localparam logic [2:0] S_XWAIT  = 3'd3;
  localparam logic [2:0] S_YSTART = 3'd4;
  localparam logic [2:0] S_YWAIT  = 3'd5;
  localparam logic [2:0] S_FETCH  = 3'd6;
  localparam logic [2:0] S_USE    = 3'd7;

  logic signed [COORD_BITS-1:0] origin_x, origin_y, empty_height;
  logic [SPACING_BITS-1:0]      cell_spacing;
  logic [SIZE_BITS-1:0]         grid_columns, grid_rows;

  logic [2:0]                state;
  logic [FILL_ADDR_BITS-1:0] clr_cnt;
  logic [1:0]                op;
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [ROW_BITS-1:0]       row;
  logic [COL_BITS-1:0]       col;

  logic [SIZE_BITS-1:0] cols_eff, rows_eff, cnt_sel, cnt_last;
  logic [SIZE_BITS-1:0] cols_last, rows_last;
  logic                 neg_sel;
  logic [COL_BITS-1:0]  idx;
  logic [ROW_BITS-1:0]  rd_row;
  logic [COL_BITS-1:0]  rd_col;
  logic                 accept, cfg_write, out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [ADDR_BITS-1:0]      cell_addr;
  logic [COORD_BITS-1:0]     height_rd;
  logic [FILL_WIDTH-1:0]     fill_rd, fill_wdata;
  logic [FILL_ADDR_BITS-1:0] fill_waddr;
  logic                      fill_we, filled, update;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Sizes of zero count as one; sizes above the memory's limits count as the limits.
  always_comb begin
    if (grid_columns == '0) begin
      cols_eff = SIZE_BITS'(1);
    end else if (grid_columns > SIZE_BITS'(MAX_COLUMNS)) begin
      cols_eff = SIZE_BITS'(MAX_COLUMNS);
    end else begin
      cols_eff = grid_columns;
    end
    if (grid_rows == '0) begin
      rows_eff = SIZE_BITS'(1);
    end else if (grid_rows > SIZE_BITS'(MAX_ROWS)) begin
      rows_eff = SIZE_BITS'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    cols_last = SIZE_BITS'(cols_eff - 1'b1);
    rows_last = SIZE_BITS'(rows_eff - 1'b1);
  end

  always_comb begin
    rd_row = ({1'b0, s_tdata[103:96]} >= rows_eff) ? rows_last[ROW_BITS-1:0]
                                                   : s_tdata[103:96];
    rd_col = ({1'b0, s_tdata[111:104]} >= cols_eff) ? cols_last[COL_BITS-1:0]
                                                    : s_tdata[111:104];
  end

  // Clamp the quotient into the grid: negative offsets land in the first cell.
  always_comb begin
    cnt_sel  = (state == S_XWAIT) ? cols_eff : rows_eff;
    cnt_last = (state == S_XWAIT) ? cols_last : rows_last;
    neg_sel  = (state == S_XWAIT) ? diff_x[COORD_BITS] : diff_y[COORD_BITS];
    if (neg_sel) begin
      idx = '0;
    end else if (div_rsp.quotient >= {{(DIV_BITS-SIZE_BITS){1'b0}}, cnt_sel}) begin
      idx = cnt_last[COL_BITS-1:0];
    end else begin
      idx = div_rsp.quotient[COL_BITS-1:0];
    end
  end

  always_comb begin
    div_req.start    = (state == S_XSTART) || (state == S_YSTART);
    div_req.dividend = (state == S_XSTART) ? diff_x[DIV_BITS-1:0] : diff_y[DIV_BITS-1:0];
    div_req.divisor  = cell_spacing;
  end

  mhgb_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cell_addr = {row, col};
  assign filled    = fill_rd[cell_addr[FILL_SEL_BITS-1:0]];
  assign update    = (state == S_USE) && (op == OP_ADD) &&
                     (!filled || ($signed(height_rd) < point_z));

  always_comb begin
    if (state == S_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt;
      fill_wdata = '0;
    end else begin
      fill_we    = update;
      fill_waddr = cell_addr[ADDR_BITS-1:FILL_SEL_BITS];
      fill_wdata = fill_rd | (FILL_WIDTH'(1) << cell_addr[FILL_SEL_BITS-1:0]);
    end
  end

  mhgb_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (CELL_COUNT)
  ) u_height_ram (
    .clk   (clk),
    .we    (update),
    .waddr (cell_addr),
    .wdata (point_z),
    .raddr (cell_addr),
    .rdata (height_rd)
  );

  mhgb_ram #(
    .WIDTH (FILL_WIDTH),
    .DEPTH (FILL_DEPTH)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (cell_addr[ADDR_BITS-1:FILL_SEL_BITS]),
    .rdata (fill_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_spacing <= SPACING_BITS'(1000);
      grid_columns <= SIZE_BITS'(256);
      grid_rows    <= SIZE_BITS'(256);
      empty_height <= COORD_BITS'(-9999000);
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X:     origin_x     <= pwdata;
        REG_ORIGIN_Y:     origin_y     <= pwdata;
        REG_CELL_SPACING: cell_spacing <= pwdata[SPACING_BITS-1:0];
        REG_GRID_COLUMNS: grid_columns <= pwdata[SIZE_BITS-1:0];
        REG_GRID_ROWS:    grid_rows    <= pwdata[SIZE_BITS-1:0];
        REG_EMPTY_HEIGHT: empty_height <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X:     prdata = origin_x;
      REG_ORIGIN_Y:     prdata = origin_y;
      REG_CELL_SPACING: prdata = {{(32-SPACING_BITS){1'b0}}, cell_spacing};
      REG_GRID_COLUMNS: prdata = {{(32-SIZE_BITS){1'b0}}, grid_columns};
      REG_GRID_ROWS:    prdata = {{(32-SIZE_BITS){1'b0}}, grid_rows};
      REG_EMPTY_HEIGHT: prdata = empty_height;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A read finishing in this cycle reloads the output register itself.
      if (m_tvalid && m_tready && !(state == S_USE && op == OP_READ)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FILL_ADDR_BITS'(FILL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op      <= s_tuser;
            point_z <= s_tdata[95:64];
            diff_x  <= $signed({s_tdata[31], s_tdata[31:0]}) -
                       $signed({origin_x[COORD_BITS-1], origin_x});
            diff_y  <= $signed({origin_y[COORD_BITS-1], origin_y}) -
                       $signed({s_tdata[63], s_tdata[63:32]});
            row     <= rd_row;
            col     <= rd_col;
            case (s_tuser)
              OP_ADD:   state <= S_XSTART;
              OP_READ:  state <= S_FETCH;
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_XSTART: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_rsp.done) begin
            col   <= idx;
            state <= S_YSTART;
          end
        end
        S_YSTART: state <= S_YWAIT;
        S_YWAIT: begin
          if (div_rsp.done) begin
            row   <= idx[ROW_BITS-1:0];
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_USE;
        S_USE: begin
          // The memory address stays put, so the read data holds while stalled.
          if (op == OP_ADD) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= filled ? height_rd : empty_height;
            m_tuser[0] <= !filled;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/mhgb_checker.sv =====
`include "max_height_grid_binning_macros.svh"

module mhgb_checker
  import mhgb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // A result that is not taken stays on the port unchanged.
  `MHGB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // An add or a clear keeps the block busy in the following cycle.
  `MHGB_ASSERT_NEXT(a_busy_after_work, s_tvalid && s_tready && (s_tuser == OP_ADD || s_tuser == OP_CLEAR), !s_tready, "ready right after add or clear")

  // Only a read produces a result.
  `MHGB_ASSERT_NEXT(a_no_spurious_out, s_tvalid && s_tready && s_tuser != OP_READ && !m_tvalid, !m_tvalid, "result without a read")

  // A read into an empty output register shows its result after the fetch and use states.
  `MHGB_ASSERT_NEXT(a_read_latency, s_tvalid && s_tready && s_tuser == OP_READ && !m_tvalid, ##2 m_tvalid, "read result missing")

endmodule

bind max_height_grid_binning mhgb_checker u_mhgb_checker (.*);

// ===== tb/tb_max_height_grid_binning.sv =====
module tb_max_height_grid_binning;
  timeunit 1ns;
  timeprecision 1ps;
  import mhgb_pkg::*;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [31:0] EMPTY_AT_RESET = -9999000;
  // A clear sweeps 1024 flag rows; an add runs two divisions.
  localparam int unsigned SETTLE_CYCLES  = 1100;
  localparam int unsigned PHASE_WORDS    = 220;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [31:0] height;
    logic        empty;
  } cell_rd_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  row;
    logic [7:0]  col;
    bit          typed;
    logic [31:0] height;
    logic        empty;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] eh;
    logic [19:0] sp;
    logic [8:0]  cols;
    logic [8:0]  rows;
  } grid_setting_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;  // point_x, point_y, point_z, read_row, read_column
  logic [1:0]   s_tuser;  // operation
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;  // cell_height
  logic [0:0]   m_tuser;  // cell_empty
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  max_height_grid_binning dut (.*);

  // Height map as the block should hold it.
  logic signed [31:0] org_x;
  logic signed [31:0] org_y;
  logic signed [31:0] blank_height;
  logic [19:0]        spacing;
  logic [8:0]         n_cols;
  logic [8:0]         n_rows;
  logic signed [31:0] peak_height [CELL_COUNT];
  bit                 cell_hit [CELL_COUNT];
  logic [7:0]         last_row;
  logic [7:0]         last_col;

  cell_rd_t    cell_reads [$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned burst_left;

  stim_row_t directed [22] = '{
    '{OP_READ, 0, 0, 0, 8'd0, 8'd0, 1'b1, EMPTY_AT_RESET, 1'b1},
    '{OP_READ, 0, 0, 0, 8'd255, 8'd255, 1'b1, EMPTY_AT_RESET, 1'b1},
    '{OP_ADD, 1500, -2500, 100, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_ADD, 1999, -2001, 50, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_ADD, 1000, -2999, 200, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd2, 8'd1, 1'b0, 0, 1'b0},
    '{OP_ADD, -5000, 5000, 32'h8000_0000, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_ADD, -1, 1, 32'h8000_0000, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, -1, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd255, 8'd255, 1'b0, 0, 1'b0},
    '{OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 12345, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_UNUSED, -1, -1, -1, 8'd255, 8'd255, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd255, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd0, 8'd255, 1'b0, 0, 1'b0},
    '{OP_CLEAR, 0, 0, 0, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd2, 8'd1, 1'b1, EMPTY_AT_RESET, 1'b1},
    '{OP_READ, 0, 0, 0, 8'd255, 8'd255, 1'b1, EMPTY_AT_RESET, 1'b1},
    '{OP_ADD, 255999, -255999, -7, 8'd0, 8'd0, 1'b0, 0, 1'b0},
    '{OP_READ, 0, 0, 0, 8'd255, 8'd255, 1'b0, 0, 1'b0}
  };

  function automatic int unsigned used_size(logic [8:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned bin_of(longint diff, int unsigned count);
    longint q;
    if (diff < 0) return 0;
    q = diff / ((spacing == 0) ? 64'sd1 : longint'(spacing));
    if (q >= count) return count - 1;
    return int'(q);
  endfunction

  // A coordinate that mostly lands inside the grid, now and then just outside it.
  function automatic logic [31:0] near_coord(logic signed [31:0] org, int unsigned count,
                                             bit down);
    longint step;
    longint off;
    step = (spacing == 0) ? 64'sd1 : longint'(spacing);
    off = longint'($urandom_range(0, count + 1)) * step
        + longint'($urandom_range(0, 32'(step - 1)));
    if ($urandom_range(0, 7) == 0) off = off - step;
    return down ? 32'(longint'(org) - off) : 32'(longint'(org) + off);
  endfunction

  task automatic bin_word(input logic [1:0] op, input logic [111:0] w, input bit typed,
                          input cell_rd_t typed_val);
    int unsigned col;
    int unsigned row;
    int unsigned cols;
    int unsigned rows;
    int unsigned addr;
    logic signed [31:0] z;
    cols = used_size(n_cols, MAX_COLUMNS);
    rows = used_size(n_rows, MAX_ROWS);
    case (op)
      OP_ADD: begin
        col = bin_of(longint'($signed(w[31:0])) - longint'(org_x), cols);
        row = bin_of(longint'(org_y) - longint'($signed(w[63:32])), rows);
        z = w[95:64];
        addr = row * MAX_COLUMNS + col;
        if (!cell_hit[addr] || peak_height[addr] < z) begin
          peak_height[addr] = z;
          cell_hit[addr] = 1'b1;
        end
        last_row = row[7:0];
        last_col = col[7:0];
      end
      OP_READ: begin
        row = 32'(w[103:96]);
        col = 32'(w[111:104]);
        if (row >= rows) row = rows - 1;
        if (col >= cols) col = cols - 1;
        addr = row * MAX_COLUMNS + col;
        if (typed) cell_reads.push_back(typed_val);
        else if (cell_hit[addr]) cell_reads.push_back('{peak_height[addr], 1'b0});
        else cell_reads.push_back('{blank_height, 1'b1});
      end
      OP_CLEAR: begin
        foreach (cell_hit[i]) cell_hit[i] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] op, input logic [111:0] w, input bit typed,
                           input cell_rd_t typed_val);
    int unsigned gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bin_word(op, w, typed, typed_val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cell_reads.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:     org_x = val;
      REG_ORIGIN_Y:     org_y = val;
      REG_CELL_SPACING: spacing = val[19:0];
      REG_GRID_COLUMNS: n_cols = val[8:0];
      REG_GRID_ROWS:    n_rows = val[8:0];
      REG_EMPTY_HEIGHT: blank_height = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what);
    if (errors < 10) $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin : result_check
    cell_rd_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (cell_reads.size() == 0) begin
        flag_mismatch($sformatf("unexpected word height %h empty %b", m_tdata, m_tuser));
      end else begin
        want = cell_reads.pop_front();
        if (m_tdata !== want.height)
          flag_mismatch($sformatf("cell_height expected %h got %h", want.height, m_tdata));
        if (m_tuser[0] !== want.empty)
          flag_mismatch($sformatf("cell_empty expected %b got %b", want.empty, m_tuser));
      end
    end
  end

  initial begin : sink
    int unsigned run_len;
    int unsigned mode;
    int unsigned hold_at;
    m_tready = 1'b0;
    hold_at = 60;
    forever begin
      if (results_seen >= hold_at) begin
        // Long hold so that pending reads back up and the input stalls.
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
        hold_at = (hold_at < 400) ? 400 : 32'hFFFF_FFFF;
      end
      run_len = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    grid_setting_t plan [7];
    grid_setting_t cfg;
    stim_row_t     step_row;
    int unsigned   done;
    int unsigned   pick;
    int unsigned   cols;
    int unsigned   rows;
    logic [1:0]    op;
    logic [31:0]   x;
    logic [31:0]   y;
    logic [31:0]   z;
    logic [7:0]    rr;
    logic [7:0]    rc;
    bit            paused;

    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    errors = 0;
    results_seen = 0;
    burst_left = 0;
    org_x = 0;
    org_y = 0;
    spacing = 20'd1000;
    n_cols = 9'd256;
    n_rows = 9'd256;
    blank_height = EMPTY_AT_RESET;
    foreach (cell_hit[i]) cell_hit[i] = 1'b0;

    plan = '{
      '{-100000, 50000, EMPTY_AT_RESET, 20'd1000, 9'd16, 9'd12},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF, 9'd256, 9'd256},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0, 9'd0, 9'd0},
      '{12345, -6789, 0, 20'd1, 9'd511, 9'd300},
      '{0, 0, 0, 20'd7, 9'd5, 9'd3},
      '{0, 0, -1, 20'd250, 9'd1, 9'd256},
      '{0, 0, 0, 20'd0, 9'd0, 9'd0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      step_row = directed[i];
      send_word(step_row.op,
                {step_row.col, step_row.row, step_row.z, step_row.y, step_row.x},
                step_row.typed, '{step_row.height, step_row.empty});
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      cfg = plan[p];
      if (p == 4) begin
        cfg.ox = $urandom_range(0, 2000000) - 1000000;
        cfg.oy = $urandom_range(0, 2000000) - 1000000;
        cfg.eh = $urandom();
      end else if (p == 6) begin
        cfg.ox = $urandom();
        cfg.oy = $urandom();
        cfg.eh = $urandom();
        cfg.sp = 20'($urandom_range(1, 5000));
        cfg.cols = 9'($urandom_range(1, 40));
        cfg.rows = 9'($urandom_range(1, 40));
      end
      // Bits above a narrow register are set at random; the block drops them.
      reg_write(REG_ORIGIN_X, cfg.ox);
      reg_write(REG_ORIGIN_Y, cfg.oy);
      reg_write(REG_CELL_SPACING, ($urandom() & 32'hFFF0_0000) | 32'(cfg.sp));
      reg_write(REG_GRID_COLUMNS, ($urandom() & 32'hFFFF_FE00) | 32'(cfg.cols));
      reg_write(REG_GRID_ROWS, ($urandom() & 32'hFFFF_FE00) | 32'(cfg.rows));
      reg_write(REG_EMPTY_HEIGHT, cfg.eh);
      cols = used_size(n_cols, MAX_COLUMNS);
      rows = used_size(n_rows, MAX_ROWS);

      done = 0;
      paused = 1'b0;
      while (done < PHASE_WORDS) begin
        if (done == PHASE_WORDS / 2 && !paused) begin
          paused = 1'b1;
          drain();
        end
        pick = $urandom_range(0, 199);
        if (pick < 3) op = OP_CLEAR;
        else if (pick < 7) op = OP_UNUSED;
        else if (pick < 115) op = OP_ADD;
        else op = OP_READ;
        x = ($urandom_range(0, 4) == 0) ? $urandom() : near_coord(org_x, cols, 1'b0);
        y = ($urandom_range(0, 4) == 0) ? $urandom() : near_coord(org_y, rows, 1'b1);
        z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) - 8 : $urandom();
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          rr = last_row;
          rc = last_col;
        end else if (pick < 17) begin
          rr = 8'($urandom_range(0, (rows > 255) ? 255 : rows));
          rc = 8'($urandom_range(0, (cols > 255) ? 255 : cols));
        end else begin
          rr = 8'($urandom());
          rc = 8'($urandom());
        end
        send_word(op, {rc, rr, z, y, x}, 1'b0, '0);
        if (op != OP_UNUSED) done++;
      end
    end

    settle();
    if (errors == 0 && cell_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== max_height_grid_binning.f =====
+incdir+hdl
hdl/mhgb_pkg.sv
hdl/mhgb_ram.sv
hdl/mhgb_divider.sv
hdl/max_height_grid_binning.sv
hdl/mhgb_checker.sv
tb/tb_max_height_grid_binning.sv
